>>> design/dcb_pkg.sv
// Shared types, constants and table functions for the double Crystal Ball evaluator.
`default_nettype none
package dcb_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned IFB         = 24;
  localparam int unsigned CUT_W       = 24;
  localparam int unsigned Q24_W       = CUT_W + IFB - FRAC_BITS;
  localparam int unsigned V_W         = 40;
  localparam int unsigned DIV_STEPS   = V_W;
  localparam int unsigned LOG_STEPS   = IFB;
  localparam int unsigned EXP_STEPS   = IFB;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [24:0]    LOG2E_Q24 = 25'd24204406;
  localparam logic [V_W-1:0] V_SAT     = {1'b1, {(V_W-1){1'b0}}};
  localparam logic [V_W-1:0] SQ_CLAMP  = V_W'(64'd1 << 28);

  typedef enum logic [1:0] {
    REGION_LOW  = 2'd0,
    REGION_CORE = 2'd1,
    REGION_HIGH = 2'd2
  } region_e;

  typedef enum logic [2:0] {
    CFG_MEAN       = 3'd0,
    CFG_WIDTH      = 3'd1,
    CFG_LOW_CUT    = 3'd2,
    CFG_LOW_POWER  = 3'd3,
    CFG_HIGH_CUT   = 3'd4,
    CFG_HIGH_POWER = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]      mean;
    logic [30:0]      width;
    logic [CUT_W-1:0] low_cut;
    logic [CUT_W-1:0] low_power;
    logic [CUT_W-1:0] high_cut;
    logic [CUT_W-1:0] high_power;
  } cfg_t;

  typedef struct packed {
    region_e        region;
    logic [V_W-1:0] v;
  } q_item_t;

  typedef logic [EXP_STEPS-1:0][31:0] coef_tab_t;

  function automatic logic [Q24_W-1:0] q24_of(logic [CUT_W-1:0] c);
    logic [CUT_W-1:0] ce;
    ce = (c == '0) ? CUT_W'(1) : c;
    return {ce, {(IFB-FRAC_BITS){1'b0}}};
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] r;
    res = '0;
    bt  = 64'd1 << 62;
    r   = x;
    for (int j = 0; j < 32; j++) begin
      if (r >= res + bt) begin
        r   = r - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic coef_tab_t exp_coefs();
    coef_tab_t   tab;
    logic [63:0] c;
    c = 64'd1 << 30;
    for (int i = 0; i < EXP_STEPS; i++) begin
      c      = isqrt64(c << 31);
      tab[i] = c[31:0];
    end
    return tab;
  endfunction

  localparam coef_tab_t EXP_COEF = exp_coefs();

endpackage
`default_nettype wire

>>> design/dcb_queue.sv
// Short item queue between the classifying front end and the evaluating back end.
`default_nettype none
module dcb_queue
  import dcb_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire q_item_t item_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output q_item_t      head_o,
  output logic         empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_item_t            mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/dcb_front.sv
// Front end: accept samples, divide the offset by the width, saturate and classify.
`default_nettype none
module dcb_front
  import dcb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] sample_i,
  output logic             push_o,
  output q_item_t          item_o,
  input  wire logic        full_i
);

  localparam int unsigned STAGES = DIV_STEPS + 3;

  typedef struct packed {
    logic [30:0]    r;
    logic [V_W-1:0] q;
    logic [15:0]    low;
    logic           neg;
    logic           ovf;
  } div_t;

  function automatic div_t div_step(div_t s, logic [30:0] w);
    div_t        o;
    logic [31:0] t;
    o     = s;
    t     = {s.r, s.low[15]};
    o.low = {s.low[14:0], 1'b0};
    if (t >= {1'b0, w}) begin
      o.r = 31'(t - {1'b0, w});
      o.q = {s.q[V_W-2:0], 1'b1};
    end else begin
      o.r = t[30:0];
      o.q = {s.q[V_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [STAGES-1:0] vld_q;
  logic              en;
  logic [32:0]       diff;
  logic [32:0]       mag;
  logic [30:0]       w_eff;
  logic              a_neg_q;
  logic [32:0]       a_mag_q;
  div_t              div_q [DIV_STEPS+1];
  q_item_t           cls_q;
  logic [V_W-1:0]    v;
  logic [V_W-1:0]    al, ah;

  assign en         = !(vld_q[STAGES-1] && full_i);
  assign in_stall_o = vld_q[STAGES-1] && full_i;
  assign push_o     = vld_q[STAGES-1] && !full_i;
  assign item_o     = cls_q;

  always_comb begin
    diff  = {sample_i[31], sample_i} - {cfg_i.mean[31], cfg_i.mean};
    mag   = diff[32] ? (33'd0 - diff) : diff;
    w_eff = (cfg_i.width == '0) ? 31'd1 : cfg_i.width;
    al    = V_W'(q24_of(cfg_i.low_cut));
    ah    = V_W'(q24_of(cfg_i.high_cut));
    if (div_q[DIV_STEPS].ovf || (div_q[DIV_STEPS].q > V_SAT)) begin
      v = V_SAT;
    end else begin
      v = div_q[DIV_STEPS].q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_neg_q <= diff[32];
      a_mag_q <= mag;
      div_q[0].r   <= {14'd0, a_mag_q[32:16]};
      div_q[0].q   <= '0;
      div_q[0].low <= a_mag_q[15:0];
      div_q[0].neg <= a_neg_q;
      div_q[0].ovf <= ({14'd0, a_mag_q} >= {w_eff, 16'd0});
      for (int i = 0; i < DIV_STEPS; i++) begin
        div_q[i+1] <= div_step(div_q[i], w_eff);
      end
      cls_q.v <= v;
      if (div_q[DIV_STEPS].neg && (v > al)) begin
        cls_q.region <= REGION_LOW;
      end else if (div_q[DIV_STEPS].neg || (v < ah)) begin
        cls_q.region <= REGION_CORE;
      end else begin
        cls_q.region <= REGION_HIGH;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/dcb_back.sv
// Back end: Gaussian exponent or power-law tail exponent, then the 2^-F evaluation.
`default_nettype none
module dcb_back
  import dcb_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  input  wire q_item_t head_i,
  input  wire logic    empty_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output logic [31:0]  density_o,
  output logic [1:0]   region_o
);

  localparam int unsigned STAGES = LOG_STEPS + EXP_STEPS + 10;

  typedef struct packed {
    logic [31:0]      md;
    logic [31:0]      mn;
    logic [IFB-1:0]   fd;
    logic [IFB-1:0]   fn;
    logic [5:0]       kd;
    logic [4:0]       kn;
    logic [33:0]      g;
    logic [Q24_W-1:0] n;
    region_e          region;
  } log_t;

  typedef struct packed {
    logic [31:0]    acc;
    logic [IFB-1:0] fp;
    logic [4:0]     sh;
    logic           zero;
    region_e        region;
  } exp_t;

  function automatic logic [5:0] lead48(logic [47:0] x);
    logic [5:0] k;
    k = '0;
    for (int i = 0; i < 48; i++) begin
      if (x[i]) begin
        k = 6'(i);
      end
    end
    return k;
  endfunction

  function automatic log_t log_step(log_t s);
    log_t        o;
    logic [63:0] pd, pn;
    o  = s;
    pd = 64'(s.md) * 64'(s.md);
    pn = 64'(s.mn) * 64'(s.mn);
    if (pd[63]) begin
      o.md = pd[63:32];
      o.fd = {s.fd[IFB-2:0], 1'b1};
    end else begin
      o.md = pd[62:31];
      o.fd = {s.fd[IFB-2:0], 1'b0};
    end
    if (pn[63]) begin
      o.mn = pn[63:32];
      o.fn = {s.fn[IFB-2:0], 1'b1};
    end else begin
      o.mn = pn[62:31];
      o.fn = {s.fn[IFB-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic exp_t exp_step(exp_t s, int unsigned j);
    exp_t        o;
    logic [63:0] p;
    o = s;
    p = 64'(s.acc) * 64'(EXP_COEF[j]);
    if (s.fp[IFB-1-j]) begin
      o.acc = p[62:31];
    end
    return o;
  endfunction

  logic [STAGES-1:0] vld_q;
  logic              en;

  logic [Q24_W-1:0] a_sel, n_sel;
  logic [V_W-1:0]   s_sel;

  region_e          s0_region_q;
  logic [28:0]      s0_sc_q;
  logic [V_W-1:0]   s0_t_q;
  logic [Q24_W-1:0] s0_a_q, s0_n_q;

  region_e          s1_region_q;
  logic [57:0]      s1_sq_q;
  logic [51:0]      s1_pl_q, s1_ph_q;
  logic [Q24_W-1:0] s1_n_q;

  logic [71:0]      at;
  region_e          s2_region_q;
  logic [57:0]      s2_gm_q;
  logic [47:0]      s2_mulv_q;
  logic [Q24_W-1:0] s2_n_q;

  region_e          s3_region_q;
  logic [33:0]      s3_g_q;
  logic [47:0]      s3_den_q;
  logic [Q24_W-1:0] s3_n_q;

  region_e          s4_region_q;
  logic [33:0]      s4_g_q;
  logic [47:0]      s4_den_q;
  logic [Q24_W-1:0] s4_n_q;
  logic [5:0]       s4_kd_q;
  logic [4:0]       s4_kn_q;
  logic [47:0]      den_norm;

  log_t             lg_q [LOG_STEPS+1];

  logic [6:0]       kdiff;
  logic [31:0]      dsum;
  region_e          s6_region_q;
  logic [33:0]      s6_g_q;
  logic [Q24_W-1:0] s6_n_q;
  logic [29:0]      s6_d_q;

  region_e          s7_region_q;
  logic [33:0]      s7_g_q;
  logic [61:0]      s7_pf_q;
  logic [38:0]      fsum;

  exp_t             ex_q [EXP_STEPS+1];

  logic [31:0]      out_dens_q;
  region_e          out_region_q;

  assign en          = !(vld_q[STAGES-1] && out_stall_i);
  assign pop_o       = en && !empty_i;
  assign out_valid_o = vld_q[STAGES-1];
  assign density_o   = out_dens_q;
  assign region_o    = out_region_q;

  always_comb begin
    if (head_i.region == REGION_LOW) begin
      a_sel = q24_of(cfg_i.low_cut);
      n_sel = q24_of(cfg_i.low_power);
    end else begin
      a_sel = q24_of(cfg_i.high_cut);
      n_sel = q24_of(cfg_i.high_power);
    end
    s_sel    = (head_i.region == REGION_CORE) ? head_i.v : V_W'(a_sel);
    at       = {s1_ph_q, 20'd0} + {20'd0, s1_pl_q};
    den_norm = s4_den_q << (6'd47 - s4_kd_q);
    kdiff    = {1'b0, lg_q[LOG_STEPS].kd} - {2'b0, lg_q[LOG_STEPS].kn};
    dsum     = {kdiff[6], kdiff, lg_q[LOG_STEPS].fd} - {8'd0, lg_q[LOG_STEPS].fn};
    if (s7_region_q == REGION_CORE) begin
      fsum = {5'd0, s7_g_q};
    end else begin
      fsum = {5'd0, s7_g_q} + {1'b0, s7_pf_q[61:24]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[STAGES-2:0], !empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_region_q <= head_i.region;
      s0_sc_q     <= (s_sel > SQ_CLAMP) ? SQ_CLAMP[28:0] : s_sel[28:0];
      s0_t_q      <= head_i.v - V_W'(a_sel);
      s0_a_q      <= a_sel;
      s0_n_q      <= n_sel;

      s1_region_q <= s0_region_q;
      s1_sq_q     <= 58'(s0_sc_q) * 58'(s0_sc_q);
      s1_pl_q     <= 52'(s0_a_q) * 52'(s0_t_q[19:0]);
      s1_ph_q     <= 52'(s0_a_q) * 52'(s0_t_q[39:20]);
      s1_n_q      <= s0_n_q;

      s2_region_q <= s1_region_q;
      s2_gm_q     <= 58'(s1_sq_q[57:25]) * 58'(LOG2E_Q24);
      s2_mulv_q   <= at[71:24];
      s2_n_q      <= s1_n_q;

      s3_region_q <= s2_region_q;
      s3_g_q      <= s2_gm_q[57:24];
      s3_den_q    <= {16'd0, s2_n_q} + s2_mulv_q;
      s3_n_q      <= s2_n_q;

      s4_region_q <= s3_region_q;
      s4_g_q      <= s3_g_q;
      s4_den_q    <= s3_den_q;
      s4_n_q      <= s3_n_q;
      s4_kd_q     <= lead48(s3_den_q);
      s4_kn_q     <= 5'(lead48({16'd0, s3_n_q}));

      lg_q[0].md     <= den_norm[47:16];
      lg_q[0].mn     <= s4_n_q << (5'd31 - s4_kn_q);
      lg_q[0].fd     <= '0;
      lg_q[0].fn     <= '0;
      lg_q[0].kd     <= s4_kd_q;
      lg_q[0].kn     <= s4_kn_q;
      lg_q[0].g      <= s4_g_q;
      lg_q[0].n      <= s4_n_q;
      lg_q[0].region <= s4_region_q;
      for (int i = 0; i < LOG_STEPS; i++) begin
        lg_q[i+1] <= log_step(lg_q[i]);
      end

      s6_region_q <= lg_q[LOG_STEPS].region;
      s6_g_q      <= lg_q[LOG_STEPS].g;
      s6_n_q      <= lg_q[LOG_STEPS].n;
      s6_d_q      <= dsum[31] ? '0 : dsum[29:0];

      s7_region_q <= s6_region_q;
      s7_g_q      <= s6_g_q;
      s7_pf_q     <= 62'(s6_n_q) * 62'(s6_d_q);

      ex_q[0].acc    <= 32'h8000_0000;
      ex_q[0].fp     <= fsum[IFB-1:0];
      ex_q[0].sh     <= fsum[IFB+4:IFB];
      ex_q[0].zero   <= |fsum[38:IFB+5];
      ex_q[0].region <= s7_region_q;
      for (int j = 0; j < EXP_STEPS; j++) begin
        ex_q[j+1] <= exp_step(ex_q[j], j);
      end

      out_dens_q   <= ex_q[EXP_STEPS].zero ? '0 : (ex_q[EXP_STEPS].acc >> ex_q[EXP_STEPS].sh);
      out_region_q <= ex_q[EXP_STEPS].region;
    end
  end

endmodule
`default_nettype wire

>>> design/double_crystal_ball_eval.sv
// Top level: configuration registers, front end, item queue and back end.
// Throughput: one item per cycle unless out_stall_i or a full queue holds the flow; the
// 40-step divider and the 24-step log and exp multiplier chains are fully pipelined.
// Reset: clears all valid bits and queue pointers; registers return to mean 0, width 1.0,
// cuts 1.0 and powers 2.0.
`default_nettype none
module double_crystal_ball_eval
  import dcb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] sample_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      density_o,
  output logic [1:0]       region_o
);

  cfg_t    cfg_q;
  logic    push, pop, full, empty;
  q_item_t push_item, head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mean       <= '0;
      cfg_q.width      <= 31'd65536;
      cfg_q.low_cut    <= 24'd65536;
      cfg_q.low_power  <= 24'd131072;
      cfg_q.high_cut   <= 24'd65536;
      cfg_q.high_power <= 24'd131072;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MEAN:       cfg_q.mean       <= cfg_data_i;
        CFG_WIDTH:      cfg_q.width      <= cfg_data_i[30:0];
        CFG_LOW_CUT:    cfg_q.low_cut    <= cfg_data_i[CUT_W-1:0];
        CFG_LOW_POWER:  cfg_q.low_power  <= cfg_data_i[CUT_W-1:0];
        CFG_HIGH_CUT:   cfg_q.high_cut   <= cfg_data_i[CUT_W-1:0];
        CFG_HIGH_POWER: cfg_q.high_power <= cfg_data_i[CUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dcb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .push_o     (push),
    .item_o     (push_item),
    .full_i     (full)
  );

  dcb_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head_item),
    .empty_o (empty)
  );

  dcb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head_item),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .density_o   (density_o),
    .region_o    (region_o)
  );

endmodule
`default_nettype wire

>>> sim/tb_double_crystal_ball_eval.sv
// Self-checking testbench for the double-sided Crystal Ball evaluator: predicts each result.
`timescale 1ns / 100ps
`default_nettype none
module tb_double_crystal_ball_eval;
  import dcb_pkg::*;

  localparam int unsigned PIPE_LAT = 101;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic [63:0] LOG2E = 64'd24204406;
  localparam logic [63:0] MASK24 = (64'd1 << 24) - 1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  cfg_idx_e    cfg_index_i = CFG_MEAN;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] sample_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] density_o;
  logic [1:0]  region_o;

  typedef struct packed {
    logic [31:0] density;
    region_e     region;
  } shape_t;

  logic [31:0] mean_r, width_r;
  logic [23:0] lo_cut_r, lo_pow_r, hi_cut_r, hi_pow_r;
  logic [31:0] pending_samples[$];
  shape_t      expected_shapes[$];
  logic [31:0] exp2_coef[24];
  int          errors = 0;
  longint unsigned cycles = 0;
  int          hold_off = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  double_crystal_ball_eval dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i(cfg_index_i), .cfg_data_i,
    .in_valid_i, .in_stall_o, .sample_i,
    .out_valid_o, .out_stall_i, .density_o, .region_o
  );

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res, bt, r;
    res = '0;
    bt = 64'd1 << 62;
    r = x;
    while (bt != 0) begin
      if (r >= res + bt) begin
        r = r - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    return (a >> 24) * b + (((a & MASK24) * b) >> 24);
  endfunction

  function automatic logic signed [63:0] fx_log2(logic [63:0] x);
    int k;
    logic [63:0] m, frac;
    k = 63;
    frac = '0;
    while (k > 0 && x[k] == 1'b0) k--;
    m = (k >= 31) ? (x >> (k - 31)) : (x << (31 - k));
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(k) - 24) * 64'sd16777216 + $signed(frac);
  endfunction

  function automatic logic [31:0] fx_exp2neg(logic [63:0] f);
    logic [63:0] ip, acc;
    ip = f >> 24;
    acc = 64'd1 << 31;
    if (ip >= 32) return '0;
    for (int i = 1; i <= 24; i++)
      if (f[24 - i]) acc = (acc * exp2_coef[i - 1]) >> 31;
    return 32'(acc >> ip);
  endfunction

  function automatic logic [63:0] widen(logic [23:0] r);
    return 64'(r == 0 ? 24'd1 : r) << 8;
  endfunction

  function automatic logic [31:0] tail_shape(logic [63:0] v, logic [63:0] a, logic [63:0] n);
    logic [63:0] ac, g, den, p;
    logic signed [63:0] d;
    ac = (a > (64'd1 << 28)) ? (64'd1 << 28) : a;
    g = ((fx_mul(ac, ac) >> 1) * LOG2E) >> 24;
    den = n + fx_mul(a, v - a);
    d = fx_log2(den) - fx_log2(n);
    p = fx_mul(n, d > 0 ? d : 64'd0);
    return fx_exp2neg(g + p);
  endfunction

  function automatic shape_t predict_shape(logic [31:0] s);
    logic signed [63:0] d;
    logic [63:0] mag, w, v, al, ah, vc, f;
    shape_t r;
    d = 64'($signed(s)) - 64'($signed(mean_r));
    mag = (d < 0) ? -d : d;
    w = (width_r == 0) ? 64'd1 : 64'(width_r);
    v = (mag << 24) / w;
    al = widen(lo_cut_r);
    ah = widen(hi_cut_r);
    if (v > (64'd1 << 39)) v = 64'd1 << 39;
    if (d < 0 && v > al) begin
      r.region = REGION_LOW;
      r.density = tail_shape(v, al, widen(lo_pow_r));
    end else if (d < 0 || v < ah) begin
      vc = (v > (64'd1 << 28)) ? (64'd1 << 28) : v;
      f = ((fx_mul(vc, vc) >> 1) * LOG2E) >> 24;
      r.region = REGION_CORE;
      r.density = fx_exp2neg(f);
    end else begin
      r.region = REGION_HIGH;
      r.density = tail_shape(v, ah, widen(hi_pow_r));
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_shapes.push_back(predict_shape(sample_i));
        void'(pending_samples.pop_front());
        tx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_valid_i <= 1'b1;
          sample_i <= pending_samples[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    shape_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_shapes.size() == 0) begin
          $display("%0t: unexpected item density %h region %0d", $time, density_o, region_o);
          errors++;
        end else begin
          e = expected_shapes.pop_front();
          if (density_o !== e.density) begin
            $display("%0t: density expected %h actual %h", $time, e.density, density_o);
            errors++;
          end
          if (region_o !== e.region) begin
            $display("%0t: region expected %0d actual %0d", $time, e.region, region_o);
            errors++;
          end
        end
        rx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_stall_i <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_MEAN:       mean_r = val;
      CFG_WIDTH:      width_r = {1'b0, val[30:0]};
      CFG_LOW_CUT:    lo_cut_r = val[23:0];
      CFG_LOW_POWER:  lo_pow_r = val[23:0];
      CFG_HIGH_CUT:   hi_cut_r = val[23:0];
      CFG_HIGH_POWER: hi_pow_r = val[23:0];
      default: begin
      end
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || expected_shapes.size() > 0) @(posedge clk_i);
    repeat (PIPE_LAT + 20) @(posedge clk_i);
  endtask

  task automatic set_shape(logic [31:0] m, logic [31:0] w, logic [23:0] lc, logic [23:0] lp,
                           logic [23:0] hc, logic [23:0] hp);
    write_reg(CFG_MEAN, m);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_LOW_CUT, {8'd0, lc});
    write_reg(CFG_LOW_POWER, {8'd0, lp});
    write_reg(CFG_HIGH_CUT, {8'd0, hc});
    write_reg(CFG_HIGH_POWER, {8'd0, hp});
  endtask

  function automatic logic [31:0] near_sample();
    int unsigned span;
    span = width_r * (1 << $urandom_range(0, 4));
    if (span == 0 || span > 32'h3fff_ffff) span = 32'h3fff_ffff;
    return mean_r + 32'($signed($urandom_range(0, span) - $urandom_range(0, span)));
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      pending_samples.push_back($urandom_range(0, 9) < 8 ? near_sample() : $urandom());
  endtask

  initial begin
    logic [63:0] c;
    c = 64'd1 << 30;
    for (int i = 0; i < 24; i++) begin
      c = root64(c << 31);
      exp2_coef[i] = c[31:0];
    end
    mean_r = 0;
    width_r = 32'd65536;
    lo_cut_r = 24'd65536;
    lo_pow_r = 24'd131072;
    hi_cut_r = 24'd65536;
    hi_pow_r = 24'd131072;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    pending_samples.push_back(32'h8000_0000);
    pending_samples.push_back(32'h7fff_ffff);
    pending_samples.push_back(32'h0000_0000);
    pending_samples.push_back(32'hffff_ffff);
    pending_samples.push_back(32'h0001_0000);
    pending_samples.push_back(32'hffff_0000);
    pending_samples.push_back(32'h0000_ffff);
    pending_samples.push_back(32'hfffe_ffff);
    pending_samples.push_back(32'h0003_0000);
    pending_samples.push_back(32'hfffd_0000);
    pending_samples.push_back(32'h0012_0000);
    pending_samples.push_back(32'h5555_5555);
    pending_samples.push_back(32'haaaa_aaaa);
    drain();
    set_shape(32'h8000_0000, 32'd1, 24'd0, 24'd0, 24'hff_ffff, 24'hff_ffff);
    pending_samples.push_back(32'h8000_0000);
    pending_samples.push_back(32'h7fff_ffff);
    pending_samples.push_back(32'h8000_0001);
    pending_samples.push_back(32'h0000_0000);
    drain();
    set_shape(32'h7fff_ffff, 32'h7fff_ffff, 24'd1, 24'd1, 24'd1, 24'd1);
    pending_samples.push_back(32'h8000_0000);
    pending_samples.push_back(32'h7fff_ffff);
    pending_samples.push_back(32'h0000_0000);
    drain();
    set_shape(32'h0000_0000, 32'd0, 24'h02_0000, 24'h03_0000, 24'h01_8000, 24'h00_8000);
    pending_samples.push_back(32'h0000_0001);
    pending_samples.push_back(32'hffff_fffd);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      set_shape($urandom(), $urandom_range(1, 32'h0010_0000) << $urandom_range(0, 10),
                24'($urandom_range(1, 24'h05_0000)), 24'($urandom_range(1, 24'h0a_0000)),
                24'($urandom_range(1, 24'h05_0000)), 24'($urandom_range(1, 24'h0a_0000)));
      if (ph == 2) hold_off = 400;
      random_phase(210);
      drain();
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
